FILE: rtl/fbpa_pkg.sv
// Shared constants and codes for the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    // Pool geometry
    localparam int NUM_BLOCKS  = 16;
    localparam int BLOCK_BYTES = 64;

    // Stack index and depth widths
    localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int DEPTH_W = $clog2(NUM_BLOCKS + 1);

    // Bytes covered by the pool, kept one bit wider than an address
    localparam logic [32:0] POOL_BYTES = 33'(NUM_BLOCKS * BLOCK_BYTES);

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator.sv
// Top level: LIFO free-list allocator for a pool of equal-size blocks.
//
// Usage
// - Input channel (i_in_valid / o_in_stall) carries one beat per operation:
//   i_op selects init, allocate or free; i_address is the block to free.
// - Output channel (o_out_valid / i_out_stall) returns one beat per input
//   beat: status, allocated block address and the free count after the op.
// - Config channel (i_cfg_valid / o_cfg_ready) writes pool_base; write it
//   only while no operation is in flight. Ready is always high.
// Sequencing (receiver not stalling)
// - Free, unused op, empty allocate: S_FIN, then the output register;
//   allocate goes through S_ALLOC first for the registered stack read;
//   init: S_INIT, one stack entry written per cycle, single write port.
// - The result sits in an output register; the next beat is taken while
//   a finished result is still waiting on a stalled receiver.
// - When the receiver stalls, the result holds; a second finished result
//   waits in the block and the input side stalls until it moves.
// Reset
// - Free list empty (count 0), pool_base 0, no result pending. Stack
//   entries are undefined until init or free writes them.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // operation input
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [OP_W-1:0]        i_op,
    input  wire  [ADDR_W-1:0]      i_address,
    // result output
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [ADDR_W-1:0]      o_block_address,
    output logic [COUNT_W-1:0]     o_free_count,
    // pool_base write
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [ADDR_W-1:0]      i_cfg_data
);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a beat
    localparam logic [1:0] S_INIT  = 2'd1;  // filling the stack
    localparam logic [1:0] S_ALLOC = 2'd2;  // stack read in flight
    localparam logic [1:0] S_FIN   = 2'd3;  // result ready for output reg

    // Free stack memory, synchronous read
    t_addr r_stack [NUM_BLOCKS];
    t_addr r_rd_data;

    logic [1:0]          r_state, n_state;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    t_addr               r_pool_base;
    logic [IDX_W-1:0]    r_fill_idx, n_fill_idx;
    t_addr               r_fill_addr, n_fill_addr;

    // Result waiting for the output register
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    t_addr               r_res_block, n_res_block;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_addr               r_out_block;
    logic [COUNT_W-1:0]  r_out_count;

    logic                w_accept;
    logic                w_out_load;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_idx;
    t_addr               w_wr_data;
    logic [IDX_W-1:0]    w_rd_idx;
    logic [DEPTH_W-1:0]  w_depth_m1;
    logic [32:0]         w_addr33;
    logic [32:0]         w_base33;
    logic [32:0]         w_end33;
    logic                w_in_pool;
    logic [DEPTH_W+COUNT_W-1:0] w_count_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_load  = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // Range check; the end does not wrap, so a pool past 2^32 takes all
    // addresses from the base up.
    assign w_addr33  = {1'b0, i_address};
    assign w_base33  = {1'b0, r_pool_base};
    assign w_end33   = w_base33 + POOL_BYTES;
    assign w_in_pool = (w_addr33 >= w_base33) && (w_addr33 < w_end33);

    // Top of stack for a pop
    assign w_depth_m1 = r_depth - DEPTH_W'(1);
    assign w_rd_idx   = w_depth_m1[IDX_W-1:0];

    // Free count, masked to the output width
    assign w_count_ext = {{COUNT_W{1'b0}}, r_depth};

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_fill_idx   = r_fill_idx;
        n_fill_addr  = r_fill_addr;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_depth[IDX_W-1:0];
        w_wr_data    = i_address;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_status = ST_OK;
                    n_res_block  = '0;
                    n_state      = S_FIN;
                    case (i_op)
                        OP_INIT: begin
                            n_fill_idx  = '0;
                            n_fill_addr = r_pool_base;
                            n_state     = S_INIT;
                        end
                        OP_ALLOC: begin
                            if (r_depth == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_depth = w_depth_m1;
                                n_state = S_ALLOC;
                            end
                        end
                        OP_FREE: begin
                            if (i_address == '0 || !w_in_pool) begin
                                n_res_status = ST_REJECT;
                            end else if (r_depth == DEPTH_W'(NUM_BLOCKS)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_depth = r_depth + DEPTH_W'(1);
                            end
                        end
                        default: begin
                            // unused op: no change, plain ok result
                        end
                    endcase
                end
            end
            S_INIT: begin
                w_wr_en     = 1'b1;
                w_wr_idx    = r_fill_idx;
                w_wr_data   = r_fill_addr;
                n_fill_idx  = r_fill_idx + IDX_W'(1);
                n_fill_addr = r_fill_addr + ADDR_W'(BLOCK_BYTES);
                if (r_fill_idx == IDX_W'(NUM_BLOCKS - 1)) begin
                    n_depth = DEPTH_W'(NUM_BLOCKS);
                    n_state = S_FIN;
                end
            end
            S_ALLOC: begin
                n_res_block = r_rd_data;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_idx] <= w_wr_data;
        end
        r_rd_data <= r_stack[w_rd_idx];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_pool_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool_base <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_fill_idx   <= n_fill_idx;
        r_fill_addr  <= n_fill_addr;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_block  <= r_res_block;
            r_out_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_block_address = r_out_block;
    assign o_free_count    = r_out_count;

endmodule

`default_nettype wire
